// ----- rtl/s2i_pkg.sv -----
// s2i_pkg: types and constants shared by the string to integer converter.
// No dependencies; s2i_front, s2i_back, the core and the checker import this package.
package s2i_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_NUMBER_BASE = 2'd0;
	localparam logic [1:0] REG_LOW_LIMIT   = 2'd1;
	localparam logic [1:0] REG_HIGH_LIMIT  = 2'd2;

	localparam logic [5:0]  RESET_BASE      = 6'd10;
	localparam logic [31:0] RESET_LOW_LIMIT = 32'h8000_0000;
	localparam logic [31:0] RESET_HIGH_LIMIT = 32'h7FFF_FFFF;

	// Radix handling
	localparam logic [5:0] MAX_BASE   = 6'd36;
	localparam logic [5:0] AUTO_BASE  = 6'd0;
	localparam logic [5:0] ONE_BASE   = 6'd1;
	localparam logic [5:0] DEC_RADIX  = 6'd10;
	localparam logic [5:0] OCT_RADIX  = 6'd8;
	localparam logic [5:0] HEX_RADIX  = 6'd16;
	localparam logic [5:0] NO_DIGIT   = 6'd63;

	// Character codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] LETTER_OFFSET = 8'd10;

	typedef enum logic [2:0] {
		PH_DASH   = 3'd0,
		PH_WS     = 3'd1,
		PH_START  = 3'd2,
		PH_ZERO   = 3'd3,
		PH_DIGITS = 3'd4,
		PH_TRAIL  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_BAD_BASE  = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_BAD_INPUT = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	// Pre-decoded character, as queued between front and back
	typedef struct packed {
		logic       last;
		logic       space;
		logic       dash;
		logic       plus;
		logic       ws;
		logic       zero;
		logic       x;
		logic [5:0] digit;
	} char_class_t;

	typedef struct packed {
		logic [31:0] value;
		status_t     status;
	} result_t;

endpackage

// ----- rtl/s2i_fifo.sv -----
// s2i_fifo: small register-based queue with push/full and pop/empty sides.
// Depends on nothing but its parameters.
module s2i_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == FULL_COUNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/s2i_front.sv -----
// s2i_front: accepts characters and pre-decodes them for the scanner.
// Depends on s2i_pkg; feeds the character queue.
module s2i_front (
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            char_code,
	input  logic                  last_char,
	input  logic                  q_full,
	output logic                  q_push,
	output s2i_pkg::char_class_t  q_data
);
	import s2i_pkg::*;

	logic [7:0] num_off;
	logic [7:0] low_off;
	logic [7:0] up_off;

	assign full   = q_full;
	assign q_push = push && !q_full;

	assign num_off = char_code - CH_ZERO;
	assign low_off = char_code - CH_LOWER_A + LETTER_OFFSET;
	assign up_off  = char_code - CH_UPPER_A + LETTER_OFFSET;

	always_comb begin
		q_data       = '0;
		q_data.last  = last_char;
		q_data.space = (char_code == CH_SPACE);
		q_data.dash  = (char_code == CH_DASH);
		q_data.plus  = (char_code == CH_PLUS);
		q_data.ws    = (char_code >= CH_TAB) && (char_code <= CH_CR);
		q_data.zero  = (char_code == CH_ZERO);
		q_data.x     = (char_code == CH_LOWER_X) || (char_code == CH_UPPER_X);
		priority if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			q_data.digit = num_off[5:0];
		end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
			q_data.digit = low_off[5:0];
		end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
			q_data.digit = up_off[5:0];
		end else begin
			q_data.digit = NO_DIGIT;
		end
	end

endmodule

// ----- rtl/s2i_back.sv -----
// s2i_back: scan state machine with the radix multiply-accumulate, and the
// final status / range check stage. Depends on s2i_pkg; drains the char queue.
module s2i_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [5:0]            number_base,
	input  logic signed [31:0]    low_limit,
	input  logic signed [31:0]    high_limit,
	input  logic                  q_empty,
	input  s2i_pkg::char_class_t  q_data,
	output logic                  q_pop,
	input  logic                  r_full,
	output logic                  r_push,
	output s2i_pkg::result_t      r_data
);
	import s2i_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam int MW = VB + 6;
	localparam int CW = ((VB > 32) ? VB : 32) + 1;
	localparam logic [VB-1:0] LIM    = {1'b1, {(VB-1){1'b0}}};
	localparam logic [VB-1:0] LIM_P1 = {1'b1, {(VB-2){1'b0}}, 1'b1};

	typedef struct packed {
		logic toggle_dash;
		logic set_neg;
		logic to_ws;
		logic to_start;
		logic start_op;
		logic zero_pre;
		logic hex_pre;
		logic use_digit;
	} scan_ctl_t;

	// Scan state
	phase_t          phase_q, phase_n;
	logic            parity_q, parity_n;
	logic            neg_q, neg_n;
	logic [5:0]      radix_q, radix_n;
	logic [VB-1:0]   mag_q, mag_n;
	logic            ovf_q, ovf_n;
	logic            bad_q, bad_n;
	logic            digit_q, digit_n;
	logic            nonspace_q, nonspace_n;

	// Finish stage
	logic            valid_s2;
	logic            neg_s2;
	logic [VB-1:0]   mag_s2;
	logic            ovf_s2;
	logic            bad_s2;
	logic            digit_s2;
	logic            nonspace_s2;

	scan_ctl_t       ctl;
	logic            ws_path;
	logic            auto_or_hex;
	logic [5:0]      start_radix;
	logic [5:0]      radix_use;
	logic            digit_ok;
	logic [MW-1:0]   mac;
	logic            mac_over;
	logic            fin_ready;

	assign auto_or_hex = (number_base == AUTO_BASE) || (number_base == HEX_RADIX);
	assign start_radix = (number_base == AUTO_BASE) ? DEC_RADIX : number_base;

	// Decode what this character does in the current phase
	always_comb begin
		ctl     = '0;
		ws_path = 1'b0;
		if (!q_data.space) begin
			unique case (phase_q)
				PH_DASH: begin
					if (q_data.dash) begin
						ctl.toggle_dash = 1'b1;
					end else if (parity_q) begin
						ctl.set_neg  = 1'b1;
						ctl.start_op = 1'b1;
					end else begin
						ws_path = 1'b1;
					end
				end
				PH_WS:     ws_path = 1'b1;
				PH_START:  ctl.start_op = 1'b1;
				PH_ZERO: begin
					if (q_data.x) begin
						ctl.hex_pre = 1'b1;
					end else begin
						ctl.use_digit = 1'b1;
					end
				end
				PH_DIGITS: ctl.use_digit = 1'b1;
				default: ;
			endcase
			if (ws_path) begin
				priority if (q_data.ws) begin
					ctl.to_ws = 1'b1;
				end else if (q_data.plus) begin
					ctl.to_start = 1'b1;
				end else if (q_data.dash) begin
					ctl.to_start = 1'b1;
					ctl.set_neg  = 1'b1;
				end else begin
					ctl.start_op = 1'b1;
				end
			end
			if (ctl.start_op) begin
				ctl.zero_pre = auto_or_hex && q_data.zero;
				ctl.use_digit = !ctl.zero_pre;
			end
		end
	end

	// Digit unit: one multiply-accumulate by the radix
	assign radix_use = ctl.start_op ? start_radix : radix_q;
	assign digit_ok  = (radix_use != '0) && (q_data.digit < radix_use);
	assign mac       = {6'b0, mag_q} * {{VB{1'b0}}, radix_use} + {{VB{1'b0}}, q_data.digit};
	assign mac_over  = (mac > {6'b0, LIM});

	// Next phase
	always_comb begin
		priority if (ctl.use_digit) begin
			phase_n = digit_ok ? PH_DIGITS : PH_TRAIL;
		end else if (ctl.zero_pre) begin
			phase_n = PH_ZERO;
		end else if (ctl.hex_pre) begin
			phase_n = PH_DIGITS;
		end else if (ctl.to_ws) begin
			phase_n = PH_WS;
		end else if (ctl.to_start) begin
			phase_n = PH_START;
		end else begin
			phase_n = phase_q;
		end
	end

	// Next scan data
	always_comb begin
		parity_n   = parity_q ^ ctl.toggle_dash;
		neg_n      = neg_q | ctl.set_neg;
		nonspace_n = nonspace_q | !q_data.space;
		bad_n      = bad_q | (ctl.use_digit && !digit_ok);
		radix_n    = radix_q;
		digit_n    = digit_q;
		mag_n      = mag_q;
		ovf_n      = ovf_q;
		if (ctl.zero_pre) begin
			radix_n = (number_base == HEX_RADIX) ? HEX_RADIX : OCT_RADIX;
			digit_n = 1'b1;
		end else if (ctl.hex_pre) begin
			radix_n = HEX_RADIX;
			digit_n = 1'b0;
		end else if (ctl.start_op) begin
			radix_n = start_radix;
		end
		if (ctl.use_digit && digit_ok) begin
			digit_n = 1'b1;
			if (!ovf_q) begin
				if (mac_over) begin
					ovf_n = 1'b1;
					mag_n = LIM_P1;
				end else begin
					mag_n = mac[VB-1:0];
				end
			end
		end
	end

	assign fin_ready = !valid_s2 || !r_full;
	assign q_pop     = !q_empty && (!q_data.last || fin_ready);
	assign r_push    = valid_s2 && !r_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DASH;
			parity_q   <= 1'b0;
			neg_q      <= 1'b0;
			radix_q    <= '0;
			mag_q      <= '0;
			ovf_q      <= 1'b0;
			bad_q      <= 1'b0;
			digit_q    <= 1'b0;
			nonspace_q <= 1'b0;
		end else if (q_pop) begin
			if (q_data.last) begin
				phase_q    <= PH_DASH;
				parity_q   <= 1'b0;
				neg_q      <= 1'b0;
				radix_q    <= '0;
				mag_q      <= '0;
				ovf_q      <= 1'b0;
				bad_q      <= 1'b0;
				digit_q    <= 1'b0;
				nonspace_q <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				parity_q   <= parity_n;
				neg_q      <= neg_n;
				radix_q    <= radix_n;
				mag_q      <= mag_n;
				ovf_q      <= ovf_n;
				bad_q      <= bad_n;
				digit_q    <= digit_n;
				nonspace_q <= nonspace_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fin_ready) begin
			valid_s2 <= q_pop && q_data.last;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			neg_s2      <= neg_n;
			mag_s2      <= mag_n;
			ovf_s2      <= ovf_n;
			bad_s2      <= bad_n;
			digit_s2    <= digit_n;
			nonspace_s2 <= nonspace_n;
		end
	end

	// Finish: sign, status priority and range check
	logic signed [CW-1:0] mag_ext;
	logic signed [CW-1:0] sval;
	logic signed [CW-1:0] low_ext;
	logic signed [CW-1:0] high_ext;
	status_t              fin_status;

	assign mag_ext  = {{(CW-VB){1'b0}}, mag_s2};
	assign sval     = neg_s2 ? -mag_ext : mag_ext;
	assign low_ext  = {{(CW-32){low_limit[31]}}, low_limit};
	assign high_ext = {{(CW-32){high_limit[31]}}, high_limit};

	always_comb begin
		priority if (number_base > MAX_BASE) begin
			fin_status = ST_BAD_BASE;
		end else if (!nonspace_s2) begin
			fin_status = ST_EMPTY;
		end else if (number_base == ONE_BASE || !digit_s2) begin
			fin_status = ST_BAD_INPUT;
		end else if (ovf_s2 || (!neg_s2 && mag_s2 >= LIM)) begin
			fin_status = ST_RANGE;
		end else if (bad_s2) begin
			fin_status = ST_BAD_INPUT;
		end else if (sval < low_ext || sval > high_ext) begin
			fin_status = ST_RANGE;
		end else begin
			fin_status = ST_NONE;
		end
	end

	assign r_data.status = fin_status;
	assign r_data.value  = (fin_status == ST_NONE) ? sval[31:0] : '0;

endmodule

// ----- rtl/string_to_int_range_check_core.sv -----
// string_to_int_range_check_core: character-stream to signed integer with
// range check. Depends on s2i_pkg, s2i_front, s2i_fifo and s2i_back.
//
// Throughput: one character per clock unless a full result queue stalls the
// scanner, set by its radix multiply-accumulate. A result goes through the
// char queue, the finish stage and the result queue to the result side.
// Reset (arst_n low, asynchronous) empties both queues, returns the scanner
// to the dash-run phase and loads base 10 with the full 32-bit limits.
module string_to_int_range_check_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// character side
	input  logic               push,
	output logic               full,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	// result side
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] value,
	output logic [2:0]         status,
	// configuration writes
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import s2i_pkg::*;

	localparam int CHAR_DEPTH   = 4;
	localparam int RESULT_DEPTH = 2;

	// Configuration registers; the user must write them only while no string is
	// in flight (the block itself does not enforce this), so the scanner reads them directly.
	logic [5:0]         number_base_q;
	logic signed [31:0] low_limit_q;
	logic signed [31:0] high_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= RESET_BASE;
			low_limit_q   <= RESET_LOW_LIMIT;
			high_limit_q  <= RESET_HIGH_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_NUMBER_BASE: number_base_q <= cfg_data[5:0];
				REG_LOW_LIMIT:   low_limit_q   <= cfg_data;
				REG_HIGH_LIMIT:  high_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: decode each character and queue it
	char_class_t cq_wdata;
	char_class_t cq_rdata;
	logic        cq_push;
	logic        cq_full;
	logic        cq_pop;
	logic        cq_empty;

	s2i_front u_front (
		.push      (push),
		.full      (full),
		.char_code (char_code),
		.last_char (last_char),
		.q_full    (cq_full),
		.q_push    (cq_push),
		.q_data    (cq_wdata)
	);

	// Decouples the front from a stalled scanner
	s2i_fifo #(
		.WIDTH ($bits(char_class_t)),
		.DEPTH (CHAR_DEPTH)
	) u_char_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cq_push),
		.push_data (cq_wdata),
		.full      (cq_full),
		.pop       (cq_pop),
		.pop_data  (cq_rdata),
		.empty     (cq_empty)
	);

	// Back: scanner plus status stage
	result_t rq_wdata;
	result_t rq_rdata;
	logic    rq_push;
	logic    rq_full;

	s2i_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.number_base (number_base_q),
		.low_limit   (low_limit_q),
		.high_limit  (high_limit_q),
		.q_empty     (cq_empty),
		.q_data      (cq_rdata),
		.q_pop       (cq_pop),
		.r_full      (rq_full),
		.r_push      (rq_push),
		.r_data      (rq_wdata)
	);

	// Result queue; its head is what the result ports show
	s2i_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RESULT_DEPTH)
	) u_result_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rq_push),
		.push_data (rq_wdata),
		.full      (rq_full),
		.pop       (pop),
		.pop_data  (rq_rdata),
		.empty     (empty)
	);

	assign value  = rq_rdata.value;
	assign status = rq_rdata.status;

endmodule

// ----- rtl/s2i_checker.sv -----
// s2i_checker: port-level assertions for string_to_int_range_check_core.
// Depends on s2i_pkg; bound to the top level at the end of this file.
module s2i_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic signed [31:0] value,
	input logic [2:0]         status
);
	import s2i_pkg::*;

	// Queues come out of reset empty
	a_empty_in_reset: assert property (@(posedge clk)
		!arst_n |-> empty)
		else $error("result side not empty during reset");

	// A failed conversion never carries a value
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_NONE) |-> (value == '0))
		else $error("nonzero value with error status");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == ST_NONE || status == ST_BAD_BASE || status == ST_EMPTY
			|| status == ST_BAD_INPUT || status == ST_RANGE))
		else $error("status code out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(value) && $stable(status)))
		else $error("waiting item changed or vanished");

endmodule

bind string_to_int_range_check_core s2i_checker u_checker (.*);

// ----- tb/string_to_int_range_check_core_test.sv -----
// Self-checking testbench for string_to_int_range_check_core: drives strings one
// character per item and compares every result against the directed table or an in-bench converter.
// Depends on s2i_pkg and the core RTL only.
`timescale 1ns / 100ps

module string_to_int_range_check_core_test;
	import s2i_pkg::*;

	localparam int VALUE_BITS   = 32;
	localparam int HALF_PERIOD  = 4;
	localparam int RANDOM_ITEMS = 1150;
	localparam int NUM_PHASES   = 12;
	localparam int NUM_DIRECTED = 25;
	localparam int HOLD_CYCLES  = 300;   // long result-side hold to back up the block
	localparam int DRAIN_CYCLES = 8;     // extra wait once all expected results are in
	localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake before giving up
	localparam int NOT_A_DIGIT  = 99;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// how a phase picks its register values
	localparam int PLAN_FIXED       = 0;
	localparam int PLAN_RAND_LIMITS = 1;
	localparam int PLAN_RAND_ALL    = 2;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         char_code;
	logic               last_char;
	logic               empty;
	logic               pop;
	logic signed [31:0] value;
	logic [2:0]         status;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;

	string_to_int_range_check_core #(.VALUE_BITS(VALUE_BITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .char_code(char_code), .last_char(last_char),
		.empty(empty), .pop(pop), .value(value), .status(status),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ---------------------------------------------------------------
	// Converter: register copy and scan state
	// ---------------------------------------------------------------
	logic [5:0]         base_reg;
	logic signed [31:0] low_reg;
	logic signed [31:0] high_reg;

	phase_t      scan_ph;
	bit          scan_odd;      // dash run parity
	bit          scan_neg;
	logic [5:0]  scan_radix;
	logic [63:0] scan_mag;      // saturates one past the largest magnitude
	bit          scan_ovf;
	bit          scan_bad;
	bit          scan_digit_seen;
	bit          scan_any;      // saw a non-space character

	result_t     pending_results[$];
	logic [7:0]  text_q[$];
	int          errors = 0;
	int          sent_items;
	int          send_calm;
	bit          no_gaps;
	bit          hold_request;
	int          quiet_cycles = 0;
	result_t     want;

	function automatic void clear_scan();
		scan_ph         = PH_DASH;
		scan_odd        = 1'b0;
		scan_neg        = 1'b0;
		scan_radix      = '0;
		scan_mag        = '0;
		scan_ovf        = 1'b0;
		scan_bad        = 1'b0;
		scan_digit_seen = 1'b0;
		scan_any        = 1'b0;
	endfunction

	function automatic int char_digit(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c) - int'(CH_ZERO);
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			return int'(c) - int'(CH_LOWER_A) + int'(LETTER_OFFSET);
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			return int'(c) - int'(CH_UPPER_A) + int'(LETTER_OFFSET);
		return NOT_A_DIGIT;
	endfunction

	// one digit into the accumulator, anything else ends the number
	function automatic void scan_digit(logic [7:0] c);
		int          d;
		logic [63:0] lim;
		lim = 64'd1 << (VALUE_BITS - 1);
		d = char_digit(c);
		if (scan_radix == '0 || d >= int'(scan_radix)) begin
			scan_bad = 1'b1;
			scan_ph  = PH_TRAIL;
			return;
		end
		scan_digit_seen = 1'b1;
		scan_ph = PH_DIGITS;
		if (scan_ovf)
			return;
		if (scan_mag > (lim - 64'(d)) / 64'(scan_radix)) begin
			scan_ovf = 1'b1;
			scan_mag = lim + 64'd1;
		end else begin
			scan_mag = scan_mag * 64'(scan_radix) + 64'(d);
		end
	endfunction

	// first character of the number proper: may open a 0 / 0x prefix
	function automatic void scan_start(logic [7:0] c);
		if ((base_reg == AUTO_BASE || base_reg == HEX_RADIX) && c == CH_ZERO) begin
			scan_radix      = (base_reg == HEX_RADIX) ? HEX_RADIX : OCT_RADIX;
			scan_digit_seen = 1'b1;
			scan_ph         = PH_ZERO;
			return;
		end
		scan_radix = (base_reg == AUTO_BASE) ? DEC_RADIX : base_reg;
		scan_digit(c);
	endfunction

	// leading whitespace and a single sign, only reached after an even dash run
	function automatic void scan_lead(logic [7:0] c);
		scan_ph = PH_WS;
		if (c >= CH_TAB && c <= CH_CR)
			return;
		scan_ph = PH_START;
		if (c == CH_PLUS)
			return;
		if (c == CH_DASH) begin
			scan_neg = 1'b1;
			return;
		end
		scan_start(c);
	endfunction

	function automatic void scan_char(logic [7:0] c);
		case (scan_ph)
			PH_DASH: begin
				if (c == CH_DASH) begin
					scan_odd = !scan_odd;
				end else if (scan_odd) begin
					scan_neg = 1'b1;
					scan_ph  = PH_START;
					scan_start(c);
				end else begin
					scan_lead(c);
				end
			end
			PH_WS:     scan_lead(c);
			PH_START:  scan_start(c);
			PH_ZERO: begin
				if (c == CH_LOWER_X || c == CH_UPPER_X) begin
					scan_radix      = HEX_RADIX;
					scan_digit_seen = 1'b0;
					scan_ph         = PH_DIGITS;
				end else begin
					scan_digit(c);
				end
			end
			PH_DIGITS: scan_digit(c);
			default: ;
		endcase
	endfunction

	// Takes one accepted item; returns 1 with the converted result on the last char.
	function automatic bit convert_char(input logic [7:0] c, input logic fin,
			output result_t res);
		logic [63:0]        lim;
		logic signed [63:0] sval;
		lim = 64'd1 << (VALUE_BITS - 1);
		res.value  = '0;
		res.status = ST_NONE;
		if (c != CH_SPACE) begin
			scan_any = 1'b1;
			scan_char(c);
		end
		if (!fin)
			return 1'b0;
		// status priority follows the order of these tests
		if (base_reg > MAX_BASE)
			res.status = ST_BAD_BASE;
		else if (!scan_any)
			res.status = ST_EMPTY;
		else if (base_reg == ONE_BASE)
			res.status = ST_BAD_INPUT;
		else if (!scan_digit_seen)
			res.status = ST_BAD_INPUT;
		else if (scan_ovf || (!scan_neg && scan_mag > lim - 64'd1))
			res.status = ST_RANGE;
		else if (scan_bad)
			res.status = ST_BAD_INPUT;
		else begin
			sval = scan_neg ? -$signed(scan_mag) : $signed(scan_mag);
			if (sval < low_reg || sval > high_reg)
				res.status = ST_RANGE;
			else
				res.value = sval[31:0];
		end
		clear_scan();
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Random string builder
	// ---------------------------------------------------------------
	function automatic logic [7:0] digit_char(int d);
		if (d < 10)
			return CH_ZERO + 8'(d);
		return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d) - LETTER_OFFSET;
	endfunction

	function automatic void append_char(logic [7:0] c);
		text_q = {text_q, c};
	endfunction

	// Mostly well-formed numbers aimed at the 32-bit edges and the current limits,
	// with a share of noise, blank strings, bare prefixes and trailing junk.
	function automatic void compose_string();
		int                 eff;
		int                 n;
		logic signed [63:0] target;
		logic [63:0]        mag;
		bit                 want_neg;
		logic [7:0]         digits[$];
		text_q.delete();
		case ($urandom_range(0, 19))
			0: begin
				repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
				return;
			end
			1: begin
				repeat ($urandom_range(1, 3)) append_char(CH_SPACE);
				return;
			end
			default: ;
		endcase

		case ($urandom_range(0, 9))
			0: target = 64'sh7FFF_FFFF;
			1: target = 64'sh8000_0000;
			2: target = -64'sh8000_0000;
			3: target = -64'sh8000_0001;
			4: target = $signed({24'd0, 8'($urandom_range(1, 255)), 32'($urandom)});
			5, 6: target = ($urandom_range(0, 1) ? low_reg : high_reg)
				+ $signed(64'($urandom_range(0, 2))) - 64'sd1;
			7: target = $signed(32'($urandom));
			default: target = $signed(64'($urandom_range(0, 4000))) - 64'sd2000;
		endcase
		want_neg = target < 0;
		mag = want_neg ? 64'(-target) : 64'(target);
		if ($urandom_range(0, 7) == 0)
			want_neg = !want_neg;

		// sign: an odd dash run, or an even run followed by whitespace and a sign
		n = 2 * $urandom_range(0, 1);
		if (want_neg && $urandom_range(0, 1))
			n = n + 1;
		repeat (n) append_char(CH_DASH);
		if (n % 2 == 0) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) append_char(CH_TAB + 8'($urandom_range(0, 4)));
			if (want_neg)
				append_char(CH_DASH);
			else if ($urandom_range(0, 2) == 0)
				append_char(CH_PLUS);
		end else if ($urandom_range(0, 15) == 0) begin
			append_char(CH_TAB);   // whitespace is illegal after an odd run
		end
		if ($urandom_range(0, 9) == 0)
			append_char(CH_SPACE);

		// radix and prefix
		eff = (base_reg < 6'd2 || base_reg > MAX_BASE) ? int'(DEC_RADIX) : int'(base_reg);
		if ((base_reg == AUTO_BASE || base_reg == HEX_RADIX) && $urandom_range(0, 2) == 0) begin
			append_char(CH_ZERO);
			if ($urandom_range(0, 3) != 0) begin
				append_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
				eff = int'(HEX_RADIX);
			end else begin
				eff = (base_reg == AUTO_BASE) ? int'(OCT_RADIX) : int'(HEX_RADIX);
			end
		end

		if ($urandom_range(0, 11) != 0) begin
			if ($urandom_range(0, 7) == 0)
				append_char(CH_ZERO);
			do begin
				digits.push_front(digit_char(int'(mag % 64'(eff))));
				mag = mag / 64'(eff);
			end while (mag != 0);
			foreach (digits[i]) begin
				if ($urandom_range(0, 15) == 0)
					append_char(CH_SPACE);
				append_char(digits[i]);
			end
		end

		if ($urandom_range(0, 9) == 0)
			append_char(eff < 36 ? digit_char($urandom_range(eff, 35))
				: 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0)
			append_char(CH_SPACE);
		if (text_q.size() == 0)
			append_char(CH_SPACE);
	endfunction

	// ---------------------------------------------------------------
	// Character side
	// ---------------------------------------------------------------
	task automatic send_char(input logic [7:0] c, input logic fin, input bit typed,
			input result_t typed_res);
		result_t got;
		if (!no_gaps) begin
			if (send_calm > 0)
				send_calm--;
			else case ($urandom_range(0, 11))
				0: begin
					push <= 1'b0;
					repeat ($urandom_range(1, 11)) @(negedge clk);
				end
				1: send_calm = $urandom_range(20, 80);
				default: ;
			endcase
		end
		push      <= 1'b1;
		char_code <= c;
		last_char <= fin;
		do @(posedge clk); while (full);
		sent_items++;
		if (convert_char(c, fin, got)) begin
			if (typed)
				got = typed_res;
			pending_results = {pending_results, got};
		end
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_char(text_q[i], i == text_q.size() - 1, 1'b0, '0);
	endtask

	// block must be idle before a register changes
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		case (idx)
			REG_NUMBER_BASE: base_reg = data[5:0];
			REG_LOW_LIMIT:   low_reg  = data;
			REG_HIGH_LIMIT:  high_reg = data;
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Result side: random pop with bursts of gaps and calm stretches
	// ---------------------------------------------------------------
	initial begin : result_side
		int gap_left;
		int calm_left;
		bit held;
		gap_left  = 0;
		calm_left = 0;
		held      = 1'b0;
		pop       = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !held) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end
			if (gap_left > 0) begin
				pop <= 1'b0;
				gap_left--;
			end else if (no_gaps || calm_left > 0) begin
				pop <= 1'b1;
				if (calm_left > 0)
					calm_left--;
			end else begin
				case ($urandom_range(0, 15))
					0: begin
						pop <= 1'b0;
						gap_left = $urandom_range(0, 10);
					end
					1: begin
						pop <= 1'b1;
						calm_left = $urandom_range(20, 80);
					end
					default: pop <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: value %0d status %0d", value, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value) begin
					$error("value: expected %0d, actual %0d", $signed(want.value), value);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					errors++;
				end
			end
		end
	end

	// watchdog: any handshake restarts the count
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_write)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	typedef struct {
		logic [7:0]  ch;
		logic        fin;
		bit          typed;
		logic [31:0] val;
		status_t     st;
	} char_row_t;

	// reset settings: base 10, full 32-bit limits
	char_row_t directed_chars [NUM_DIRECTED] = '{
		'{CH_SPACE, 1'b1, 1'b1, 32'd0,    ST_EMPTY},      // only a space
		'{"7",      1'b1, 1'b1, 32'd7,    ST_NONE},
		'{8'h00,    1'b1, 1'b1, 32'd0,    ST_BAD_INPUT},  // NUL is a plain non-digit
		'{8'hFF,    1'b1, 1'b1, 32'd0,    ST_BAD_INPUT},
		'{CH_DASH,  1'b0, 1'b0, 32'd0,    ST_NONE},       // even dash run: positive
		'{CH_DASH,  1'b0, 1'b0, 32'd0,    ST_NONE},
		'{"5",      1'b1, 1'b1, 32'd5,    ST_NONE},
		'{CH_DASH,  1'b0, 1'b0, 32'd0,    ST_NONE},       // odd dash run: negative
		'{CH_DASH,  1'b0, 1'b0, 32'd0,    ST_NONE},
		'{CH_DASH,  1'b0, 1'b0, 32'd0,    ST_NONE},
		'{"4",      1'b1, 1'b1, -32'sd4,  ST_NONE},
		'{CH_DASH,  1'b0, 1'b0, 32'd0,    ST_NONE},
		'{"9",      1'b1, 1'b1, -32'sd9,  ST_NONE},
		'{CH_PLUS,  1'b0, 1'b0, 32'd0,    ST_NONE},       // space inside is dropped
		'{CH_SPACE, 1'b0, 1'b0, 32'd0,    ST_NONE},
		'{"1",      1'b1, 1'b1, 32'd1,    ST_NONE},
		'{CH_TAB,   1'b0, 1'b0, 32'd0,    ST_NONE},       // leading whitespace
		'{"8",      1'b1, 1'b1, 32'd8,    ST_NONE},
		'{CH_DASH,  1'b0, 1'b0, 32'd0,    ST_NONE},       // whitespace after odd run
		'{CH_TAB,   1'b0, 1'b0, 32'd0,    ST_NONE},
		'{"1",      1'b1, 1'b1, 32'd0,    ST_BAD_INPUT},
		'{"1",      1'b0, 1'b0, 32'd0,    ST_NONE},       // trailing letter
		'{"a",      1'b1, 1'b1, 32'd0,    ST_BAD_INPUT},
		'{CH_DASH,  1'b0, 1'b0, 32'd0,    ST_NONE},       // second sign after odd run
		'{CH_PLUS,  1'b1, 1'b1, 32'd0,    ST_BAD_INPUT}
	};

	typedef struct {
		logic [5:0]  base;
		logic [31:0] lo;
		logic [31:0] hi;
		int          mode;
	} reg_plan_t;

	reg_plan_t reg_plan [NUM_PHASES] = '{
		'{6'd10, RESET_LOW_LIMIT,  RESET_HIGH_LIMIT, PLAN_FIXED},
		'{6'd16, RESET_LOW_LIMIT,  RESET_HIGH_LIMIT, PLAN_FIXED},
		'{6'd0,  RESET_LOW_LIMIT,  RESET_HIGH_LIMIT, PLAN_FIXED},
		'{6'd2,  RESET_LOW_LIMIT,  RESET_HIGH_LIMIT, PLAN_FIXED},
		'{6'd36, RESET_LOW_LIMIT,  RESET_HIGH_LIMIT, PLAN_FIXED},
		'{6'd8,  32'd0,            32'd0,            PLAN_RAND_LIMITS},
		'{6'd1,  RESET_LOW_LIMIT,  RESET_HIGH_LIMIT, PLAN_FIXED},
		'{6'd37, RESET_LOW_LIMIT,  RESET_HIGH_LIMIT, PLAN_FIXED},
		'{6'd63, RESET_LOW_LIMIT,  RESET_HIGH_LIMIT, PLAN_FIXED},
		'{6'd0,  32'd0,            32'd0,            PLAN_RAND_LIMITS},
		'{6'd10, RESET_HIGH_LIMIT, RESET_LOW_LIMIT,  PLAN_FIXED},   // empty window
		'{6'd0,  32'd0,            32'd0,            PLAN_RAND_ALL}
	};

	initial begin : stimulus
		reg_plan_t   plan;
		logic [31:0] a;
		logic [31:0] b;
		int          goal;

		clk          = 1'b0;
		arst_n       = 1'b0;
		push         = 1'b0;
		char_code    = '0;
		last_char    = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		sent_items   = 0;
		send_calm    = 0;
		no_gaps      = 1'b0;
		hold_request = 1'b0;
		base_reg     = RESET_BASE;
		low_reg      = RESET_LOW_LIMIT;
		high_reg     = RESET_HIGH_LIMIT;
		clear_scan();

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_chars[i])
			send_char(directed_chars[i].ch, directed_chars[i].fin, directed_chars[i].typed,
				'{directed_chars[i].val, directed_chars[i].st});

		for (int p = 0; p < NUM_PHASES; p++) begin
			plan = reg_plan[p];
			if (plan.mode != PLAN_FIXED) begin
				a = $urandom;
				b = $urandom;
				if ($urandom_range(0, 1)) begin
					a = -32'($urandom_range(0, 3000));
					b = 32'($urandom_range(0, 3000));
				end
				if ($signed(a) > $signed(b)) begin
					plan.lo = b;
					plan.hi = a;
				end else begin
					plan.lo = a;
					plan.hi = b;
				end
				if (plan.mode == PLAN_RAND_ALL)
					plan.base = 6'($urandom_range(2, 36));
			end
			wait_idle();
			if (p == 0)
				write_reg(REG_UNUSED, $urandom);   // index with no register behind it
			// junk above the 6 base bits must be dropped
			write_reg(REG_NUMBER_BASE,
				{26'($urandom_range(0, 32'h03FF_FFFF)), 6'd0} | 32'(plan.base));
			write_reg(REG_LOW_LIMIT, plan.lo);
			write_reg(REG_HIGH_LIMIT, plan.hi);
			cfg_write <= 1'b0;

			if (p == 1)
				hold_request = 1'b1;          // results back up, char side sees full
			if (p == NUM_PHASES - 1)
				no_gaps = 1'b1;

			goal = NUM_DIRECTED + (p + 1) * RANDOM_ITEMS / NUM_PHASES;
			while (sent_items < goal) begin
				compose_string();
				send_text();
			end
		end

		push <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
